[rtl/vp8_rtp_packetizer_assert.svh]
// assertion macros shared by the packetizer modules
`ifndef VP8_RTP_PACKETIZER_ASSERT_SVH
`define VP8_RTP_PACKETIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define VRP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define VRP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VRP_ASSERT_IMP(name, ante, cons, msg)
`define VRP_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/vrp_pkg.sv]
// shared constants and types of the vp8 rtp packetizer
package vrp_pkg;

  localparam int LIMIT_W = 12;
  localparam int FILL_W = 11;
  localparam int PIC_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd1400;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN = 12'd4;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 12'd2048;
  localparam logic [LIMIT_W-1:0] HDR_BYTES = 12'd3;
  localparam logic [FILL_W-1:0] FILL_MAX = 11'd2044;

  localparam logic [7:0] DESC_FIRST = 8'h90;
  localparam logic [7:0] DESC_S_BIT = 8'h10;
  localparam logic [7:0] DESC_PICID = 8'h80;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0]       data;
    logic             hdr;
    logic             first;
    logic [PIC_W-1:0] pic_id;
    logic             pend;
    logic             mark;
  } vrp_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } vrp_qstat_t;

endpackage

[rtl/vrp_ifs.sv]
// byte stream channels of the packetizer
interface vrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  modport source(output valid, data_byte, frame_end, input ready);
  modport sink(input valid, data_byte, frame_end, output ready);
endinterface

interface vrp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       marker_bit;
  logic       run_last;
  modport source(output valid, out_byte, packet_end, marker_bit, run_last, input ready);
  modport sink(input valid, out_byte, packet_end, marker_bit, run_last, output ready);
endinterface

[rtl/vrp_front.sv]
// front end: accepts frame bytes and classifies packet boundaries
module vrp_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [vrp_pkg::LIMIT_W-1:0] cfg_data,
  vrp_in_if.sink                     byte_in,
  input  vrp_pkg::vrp_qstat_t        qstat,
  output logic                       push,
  output vrp_pkg::vrp_entry_t        entry
);
  import vrp_pkg::*;

  `include "vp8_rtp_packetizer_assert.svh"

  logic [LIMIT_W-1:0] max_payload;
  logic [PIC_W-1:0]   picture_id;
  logic [FILL_W-1:0]  packet_fill;
  logic               first_flag;

  logic [LIMIT_W-1:0] limit;
  logic [FILL_W-1:0]  cap;
  logic [FILL_W-1:0]  fill_inc;
  logic               pend;

  always_comb begin
    if (max_payload < LIMIT_MIN) begin
      limit = LIMIT_MIN;
    end else if (max_payload > LIMIT_MAX) begin
      limit = LIMIT_MAX;
    end else begin
      limit = max_payload;
    end
    cap = FILL_W'(limit - HDR_BYTES);
    fill_inc = packet_fill + 11'd1;
    pend = byte_in.frame_end || (fill_inc >= cap);
  end

  assign byte_in.ready = !qstat.full;
  assign push = byte_in.valid && byte_in.ready;

  always_comb begin
    entry.data = byte_in.data_byte;
    entry.hdr = (packet_fill == '0);
    entry.first = first_flag;
    entry.pic_id = picture_id;
    entry.pend = pend;
    entry.mark = pend && byte_in.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= LIMIT_RESET;
      picture_id <= '0;
      packet_fill <= '0;
      first_flag <= 1'b1;
    end else begin
      if (cfg_write) begin
        max_payload <= cfg_data;
      end
      if (push) begin
        packet_fill <= pend ? '0 : fill_inc;
        if (byte_in.frame_end) begin
          first_flag <= 1'b1;
          picture_id <= picture_id + 7'd1;
        end else if (packet_fill == '0) begin
          first_flag <= 1'b0;
        end
      end
    end
  end

  `VRP_ASSERT_IMP(a_first_no_open, first_flag, packet_fill == '0, "first packet flag with open packet")
  `VRP_ASSERT_IMP(a_fill_bound, 1'b1, packet_fill <= FILL_MAX, "packet fill past data capacity")

endmodule

[rtl/vrp_queue.sv]
// short queue of classified bytes between front and back
module vrp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vrp_pkg::vrp_entry_t entry,
  input  logic                pop,
  output vrp_pkg::vrp_qstat_t qstat,
  output vrp_pkg::vrp_entry_t head
);
  import vrp_pkg::*;

  `include "vp8_rtp_packetizer_assert.svh"

  vrp_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign qstat.valid = (count != '0);
  assign qstat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `VRP_ASSERT_IMP(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `VRP_ASSERT_IMP(a_no_pop_empty, pop, count != '0, "pop from empty queue")

endmodule

[rtl/vrp_back.sv]
// back end: expands queued bytes into descriptor and data beats
module vrp_back (
  input  logic                clk,
  input  logic                rst,
  input  vrp_pkg::vrp_qstat_t qstat,
  input  vrp_pkg::vrp_entry_t head,
  output logic                pop,
  vrp_out_if.source           byte_out
);
  import vrp_pkg::*;

  `include "vp8_rtp_packetizer_assert.svh"

  localparam logic [1:0] PH_DESC0 = 2'd0;
  localparam logic [1:0] PH_DESC1 = 2'd1;
  localparam logic [1:0] PH_PICID = 2'd2;
  localparam logic [1:0] PH_DATA = 2'd3;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic       load;
  logic       fire;
  logic       is_data;
  logic [7:0] beat_byte;

  assign load = !byte_out.valid || byte_out.ready;
  assign fire = load && qstat.valid;
  assign is_data = !head.hdr || (phase == PH_DATA);
  assign pop = fire && is_data;

  always_comb begin
    beat_byte = head.data;
    phase_next = phase;
    if (is_data) begin
      phase_next = PH_DESC0;
    end else begin
      unique case (phase)
        PH_DESC0: begin
          beat_byte = head.first ? DESC_FIRST : (DESC_FIRST & ~DESC_S_BIT);
          phase_next = PH_DESC1;
        end
        PH_DESC1: begin
          beat_byte = DESC_PICID;
          phase_next = PH_PICID;
        end
        PH_PICID: begin
          beat_byte = {1'b0, head.pic_id};
          phase_next = PH_DATA;
        end
        default: begin
          beat_byte = head.data;
          phase_next = PH_DESC0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DESC0;
      byte_out.valid <= 1'b0;
    end else begin
      if (fire) begin
        phase <= phase_next;
      end
      if (load) begin
        byte_out.valid <= qstat.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      byte_out.out_byte <= beat_byte;
      byte_out.packet_end <= is_data && head.pend;
      byte_out.marker_bit <= is_data && head.mark;
      byte_out.run_last <= is_data;
    end
  end

  `VRP_ASSERT_IMP(a_phase_hdr, phase != PH_DESC0, qstat.valid && head.hdr, "descriptor phase without header item")
  `VRP_ASSERT_NEXT(a_phase_hold, !fire, phase == $past(phase), "phase moved without a beat")

endmodule

[rtl/vp8_rtp_packetizer.sv]
// top level of the vp8 rtp payload packetizer
//
// byte_in takes one compressed frame byte per beat, frame_end on the last
// byte of a frame. byte_out gives one packet byte per beat: a three-byte
// payload descriptor (0x90 or 0x80, then 0x80, then the 7-bit picture id)
// ahead of the first data byte of every packet, then the data bytes.
// packet_end flags the last byte of a packet, marker_bit that byte on the
// last packet of a frame, run_last the data byte that ends each input beat.
// cfg_write/cfg_data set the largest payload including the descriptor,
// clamped to 4..2048; write it only while the block is idle.
// an accepted input beat is held in the queue, then in the single output register.
// one output beat per cycle while byte_out is ready and the queue holds a
// byte; a byte that opens a packet gives four beats and any other byte one.
// a four-entry queue lets input be taken while output is stalled; byte_in
// stalls only when that queue is full.
// reset clears the queue and output, the picture id and packet fill, and
// loads a payload limit of 1400.
module vp8_rtp_packetizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [vrp_pkg::LIMIT_W-1:0] cfg_data,
  vrp_in_if.sink                     byte_in,
  vrp_out_if.source                  byte_out
);
  import vrp_pkg::*;

  logic       push;
  logic       pop;
  vrp_entry_t entry;
  vrp_entry_t head;
  vrp_qstat_t qstat;

  vrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .byte_in   (byte_in),
    .qstat     (qstat),
    .push      (push),
    .entry     (entry)
  );

  vrp_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .pop   (pop),
    .qstat (qstat),
    .head  (head)
  );

  vrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .byte_out (byte_out)
  );

endmodule
